// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by counting_sort_engine.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_SAME_CYCLE(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);
`define ASSERT_NEXT_CYCLE(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);
`else
`define ASSERT_SAME_CYCLE(label, clk, rst, cond, expr, msg)
`define ASSERT_NEXT_CYCLE(label, clk, rst, cond, expr, msg)
`endif
`endif

// ===== hw/rtl/cse_pkg.sv =====
// types and constants of the counting sort engine
package cse_pkg;

  localparam int VALUE_W = 16;

  typedef struct packed {
    logic [VALUE_W-1:0] sample_value;
    logic               set_end;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    logic               run_end;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic               run_end;
  } emit_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_WR,
    ST_SC_RD,
    ST_SC_CHK,
    ST_SC_EMIT
  } state_t;

endpackage

// ===== hw/rtl/cse_ram.sv =====
// generic single write port ram with registered read
module cse_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/cse_seq.sv =====
// histogram sequencer: clear pass, bucket increment and ascending scan
module cse_seq #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_ITEMS  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  input  cse_pkg::in_word_t sample_word,
  output logic              sample_stall,
  input  logic              out_free,
  output cse_pkg::emit_t    emit
);

  localparam int AW    = VALUE_BITS;
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int DEPTH = 1 << VALUE_BITS;

  cse_pkg::state_t state, state_next;

  logic [CW-1:0] loaded_count;
  logic [CW-1:0] emitted;
  logic [CW-1:0] remain;
  logic [AW-1:0] scan_addr;
  logic [AW-1:0] ld_value;
  logic          ld_last;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] ram_rdata;

  logic accept;
  logic full;
  logic emit_last;

  assign accept    = sample_valid && (state == cse_pkg::ST_IDLE);
  assign full      = loaded_count == CW'(MAX_ITEMS);
  assign emit_last = (emitted + CW'(1)) == loaded_count;

  cse_ram #(
    .WIDTH(CW),
    .DEPTH(DEPTH)
  ) u_buckets (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cse_pkg::ST_CLEAR: begin
        if (scan_addr == '1) state_next = cse_pkg::ST_IDLE;
      end
      cse_pkg::ST_IDLE: begin
        if (accept) begin
          if (!full) state_next = cse_pkg::ST_LD_WR;
          else if (sample_word.set_end) state_next = cse_pkg::ST_SC_RD;
        end
      end
      cse_pkg::ST_LD_WR: begin
        state_next = ld_last ? cse_pkg::ST_SC_RD : cse_pkg::ST_IDLE;
      end
      cse_pkg::ST_SC_RD: begin
        state_next = cse_pkg::ST_SC_CHK;
      end
      cse_pkg::ST_SC_CHK: begin
        state_next = (ram_rdata == '0) ? cse_pkg::ST_SC_RD : cse_pkg::ST_SC_EMIT;
      end
      cse_pkg::ST_SC_EMIT: begin
        if (out_free) begin
          if (emit_last) state_next = cse_pkg::ST_IDLE;
          else if (remain == CW'(1)) state_next = cse_pkg::ST_SC_RD;
        end
      end
      default: state_next = cse_pkg::ST_IDLE;
    endcase
  end

  // outputs and ram port control
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = scan_addr;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = scan_addr;
    sample_stall = (state != cse_pkg::ST_IDLE);
    emit.valid   = 1'b0;
    emit.value   = cse_pkg::VALUE_W'(scan_addr);
    emit.run_end = emit_last;
    unique case (state)
      cse_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      cse_pkg::ST_IDLE: begin
        ram_re    = accept;
        ram_raddr = sample_word.sample_value[AW-1:0];
      end
      cse_pkg::ST_LD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ld_value;
        ram_wdata = ram_rdata + CW'(1);
      end
      cse_pkg::ST_SC_RD: begin
        ram_re = 1'b1;
      end
      cse_pkg::ST_SC_CHK: begin
        // bucket is cleared as it is visited
        ram_we = 1'b1;
      end
      cse_pkg::ST_SC_EMIT: begin
        emit.valid = out_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cse_pkg::ST_CLEAR;
      scan_addr    <= '0;
      loaded_count <= '0;
      emitted      <= '0;
    end else begin
      state <= state_next;
      case (state)
        cse_pkg::ST_CLEAR: begin
          scan_addr <= scan_addr + AW'(1);
        end
        cse_pkg::ST_IDLE: begin
          if (accept) begin
            ld_value  <= sample_word.sample_value[AW-1:0];
            ld_last   <= sample_word.set_end;
            scan_addr <= '0;
            emitted   <= '0;
          end
        end
        cse_pkg::ST_LD_WR: begin
          loaded_count <= loaded_count + CW'(1);
        end
        cse_pkg::ST_SC_CHK: begin
          remain <= ram_rdata;
          if (ram_rdata == '0) scan_addr <= scan_addr + AW'(1);
        end
        cse_pkg::ST_SC_EMIT: begin
          if (out_free) begin
            emitted <= emitted + CW'(1);
            remain  <= remain - CW'(1);
            if (emit_last) loaded_count <= '0;
            else if (remain == CW'(1)) scan_addr <= scan_addr + AW'(1);
          end
        end
        default: begin
          remain <= remain;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/counting_sort_engine.sv =====
// counting sort engine top level: sequencer, histogram ram and output register
// usage:
//   sample channel: one word per value (sample_word.sample_value); only the low
//   VALUE_BITS bits index the histogram. sample_word.set_end closes the set.
//   at most MAX_ITEMS values count per set, later ones are dropped, but a
//   dropped word with set_end still closes the set.
//   sorted channel: after the closing word the set comes out in ascending
//   order, one word per counted value, run_end high on the last one.
// flow:
//   a value that counts is read from the ram, then the incremented count is
//   written back; sample_stall is high during the write back. a closing word
//   is followed by the scan, which reads and clears each bucket up to the
//   largest value in the set and emits one word per count it held.
//   sample_stall stays high for the whole scan.
// reset:
//   rst is synchronous. afterwards a clearing pass zeroes the histogram, one
//   bucket a cycle, all 2^VALUE_BITS of them, with sample_stall high.
// backpressure:
//   sorted_stall holds the output register; the scan waits until it is free.
`include "assert_macros.svh"

module counting_sort_engine #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_ITEMS  = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  input  cse_pkg::in_word_t  sample_word,
  output logic               sample_stall,
  output logic               sorted_valid,
  input  logic               sorted_stall,
  output cse_pkg::out_word_t sorted_word
);

  cse_pkg::emit_t emit;
  logic           out_free;

  // the output register can take a word when empty or being drained
  assign out_free = !sorted_valid || !sorted_stall;

  cse_seq #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_word (sample_word),
    .sample_stall(sample_stall),
    .out_free    (out_free),
    .emit        (emit)
  );

  // output register parting the scan from the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_valid <= 1'b0;
    end else if (emit.valid) begin
      sorted_valid <= 1'b1;
    end else if (!sorted_stall) begin
      sorted_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      sorted_word.sorted_value <= emit.value;
      sorted_word.run_end      <= emit.run_end;
    end
  end

  // no word enters the output register while it still holds a stalled one
  `ASSERT_SAME_CYCLE(a_emit_free, clk, rst, emit.valid, out_free, "emit into busy output")
  // the scan never runs while samples are being taken
  `ASSERT_SAME_CYCLE(a_emit_stall, clk, rst, emit.valid, sample_stall, "emit while sampling")
  // the last word of a set ends the scan
  `ASSERT_NEXT_CYCLE(a_run_end, clk, rst, emit.valid && emit.run_end, !emit.valid,
                     "emit after run end")

endmodule
